>>> src/pli_pkg.sv
// Package for the piecewise linear interpolator: sizes, item types, codes.
// No dependencies.
package pli_pkg;
  localparam int MaxPoints = 64;
  localparam int IdxW = $clog2(MaxPoints);
  localparam int CntW = IdxW + 1;

  localparam logic [1:0] ModeClear = 2'd0;
  localparam logic [1:0] ModeInsert = 2'd1;
  localparam logic [1:0] ModeEval = 2'd2;
  localparam logic [1:0] ModeNone = 2'd3;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StDup = 2'd1;
  localparam logic [1:0] StFull = 2'd2;
  localparam logic [1:0] StFew = 2'd3;

  typedef struct packed {
    logic [1:0] mode;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
  } pli_in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0] status;
  } pli_out_t;
endpackage

>>> src/piecewise_linear_interpolator_unit.sv
// Top level of the piecewise linear interpolator.
// Uses pli_pkg and two pli_ram instances (point x and point y tables).
//
// Usage: drive in_i and raise start while busy is low; the item is taken at
// that edge and busy rises. One result per item appears on out_o for exactly
// one cycle with done_o high; the receiver cannot stall it. busy is low in
// that cycle, so the next item may be taken at the edge that ends it.
// Modes: clear, insert (sorted, rejecting duplicate x or a full table),
// evaluate (linear interpolation, outer segments extrapolated), unused.
// Sequence: a clear or an unused mode skips the search. Inserts and
// evaluates first search the x table, one entry at a time, up to the first
// entry not below the query. A rejected insert or a short table then ends
// the item. An insert shifts the tail up one entry at a time and writes the
// new point. An evaluate reads both segment ends, forms two 32x32 products
// and divides the 65-bit numerator by the span one quotient bit a cycle.
// A new item is taken only once the last one is done (busy low).
// Reset (asynchronous) empties the table by zeroing the count; memories are
// not cleared, only entries below the count are ever read.
module piecewise_linear_interpolator_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  pli_pkg::pli_in_t  in_i,
  output logic              done_o,
  output pli_pkg::pli_out_t out_o
);
  import pli_pkg::*;

  localparam logic [3:0] SIdle = 4'd0, SSrch = 4'd1, SSrchW = 4'd2, SDec = 4'd3,
    SShR = 4'd4, SShW = 4'd5, SRd0 = 4'd6, SRd1 = 4'd7, SRd2 = 4'd8,
    SMul0 = 4'd9, SMul1 = 4'd10, SSum = 4'd11, SDiv = 4'd12, SFin = 4'd13,
    SOut = 4'd14;

  logic [3:0] st_q, st_d;
  pli_in_t item_q;
  logic [CntW-1:0] cnt_q, pos_q, k_q;
  logic signed [31:0] x0_q, y0_q, x1_q, y1_q, xs_q;
  logic [63:0] ma_q, mb_q;
  logic na_q, nb_q, neg_q;
  logic [64:0] num_q, quo_q;
  logic [32:0] den_q;
  logic [32:0] rem_q;
  logic [6:0] bit_q;
  pli_out_t res_q;
  logic done_q;

  // memory ports
  logic we;
  logic [IdxW-1:0] waddr, raddr;
  logic [31:0] wx, wy, rx, ry;

  // search outcome
  logic dup, full;
  logic [CntW-1:0] seg;

  // multiplier and divider operands
  logic signed [32:0] ad, bd, span;
  logic [31:0] mag_d, mag_y;
  logic [63:0] prod;
  logic [33:0] trial;

  pli_ram #(.Width(32), .Depth(MaxPoints)) u_ram_x (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wx), .raddr_i(raddr), .rdata_o(rx));
  pli_ram #(.Width(32), .Depth(MaxPoints)) u_ram_y (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wy), .raddr_i(raddr), .rdata_o(ry));

  assign busy = (st_q != SIdle);
  assign done_o = done_q;
  assign out_o = res_q;

  // shared 32x32 magnitude multiplier, operands picked by state
  assign ad = {x1_q[31], x1_q} - {item_q.x_value[31], item_q.x_value};
  assign bd = {item_q.x_value[31], item_q.x_value} - {x0_q[31], x0_q};
  assign span = {x1_q[31], x1_q} - {x0_q[31], x0_q};
  always_comb begin
    if (st_q == SMul0) begin
      mag_d = ad[32] ? 32'(-ad) : 32'(ad);
      mag_y = y0_q[31] ? 32'(-{y0_q[31], y0_q}) : 32'(y0_q);
    end else begin
      mag_d = bd[32] ? 32'(-bd) : 32'(bd);
      mag_y = y1_q[31] ? 32'(-{y1_q[31], y1_q}) : 32'(y1_q);
    end
    prod = 64'(mag_d) * 64'(mag_y);
  end

  // restoring divide step
  assign trial = {rem_q, num_q[64]};

  // search outcome and clamped segment end
  assign dup = (pos_q < cnt_q) && (xs_q == item_q.x_value);
  assign full = (cnt_q == CntW'(MaxPoints));
  always_comb begin
    seg = (pos_q >= cnt_q) ? cnt_q - 1'b1 : pos_q;
    if (seg == '0) seg = CntW'(1);
  end

  // memory addressing and writes
  always_comb begin
    we = 1'b0;
    waddr = pos_q[IdxW-1:0];
    wx = item_q.x_value;
    wy = item_q.y_value;
    raddr = pos_q[IdxW-1:0];
    case (st_q)
      SShR: raddr = IdxW'(k_q - 1'b1);
      SShW: begin
        we = 1'b1;
        if (k_q != pos_q) begin
          waddr = k_q[IdxW-1:0];
          wx = rx;
          wy = ry;
        end
      end
      SRd0: raddr = IdxW'(pos_q - 1'b1);
      default: raddr = pos_q[IdxW-1:0];
    endcase
  end

  // sequencer
  always_comb begin
    st_d = st_q;
    case (st_q)
      SIdle: if (start) st_d = SSrch;
      SSrch: begin
        if (pos_q < cnt_q && (item_q.mode == ModeInsert || item_q.mode == ModeEval))
          st_d = SSrchW;
        else
          st_d = SDec;
      end
      SSrchW: st_d = ($signed(rx) < $signed(item_q.x_value)) ? SSrch : SDec;
      SDec: begin
        if (item_q.mode == ModeInsert && !dup && !full) st_d = SShR;
        else if (item_q.mode == ModeEval && cnt_q >= CntW'(2)) st_d = SRd0;
        else st_d = SOut;
      end
      SShR: st_d = SShW;
      SShW: st_d = (k_q == pos_q) ? SOut : SShR;
      SRd0: st_d = SRd1;
      SRd1: st_d = SRd2;
      SRd2: st_d = SMul0;
      SMul0: st_d = SMul1;
      SMul1: st_d = SSum;
      SSum: st_d = SDiv;
      SDiv: if (bit_q == 7'd0) st_d = SFin;
      SFin: st_d = SOut;
      SOut: st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      cnt_q <= '0;
      done_q <= 1'b0;
    end else begin
      st_q <= st_d;
      done_q <= (st_q == SOut);
      if (st_q == SDec) begin
        if (item_q.mode == ModeClear) begin
          cnt_q <= '0;
        end else if (item_q.mode == ModeInsert && !dup && !full) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (st_q)
      SIdle: begin
        item_q <= in_i;
        pos_q <= '0;
        res_q <= '0;
      end
      SSrchW: begin
        xs_q <= rx;
        if ($signed(rx) < $signed(item_q.x_value)) pos_q <= pos_q + 1'b1;
      end
      SDec: begin
        if (item_q.mode == ModeInsert) begin
          if (dup) res_q.status <= StDup;
          else if (full) res_q.status <= StFull;
          k_q <= cnt_q;
        end else if (item_q.mode == ModeEval) begin
          if (cnt_q < CntW'(2)) res_q.status <= StFew;
          pos_q <= seg;
        end
      end
      SShW: k_q <= k_q - 1'b1;
      SRd1: begin
        x0_q <= rx;
        y0_q <= ry;
      end
      SRd2: begin
        x1_q <= rx;
        y1_q <= ry;
      end
      SMul0: begin
        ma_q <= prod;
        na_q <= (ad[32] != y0_q[31]);
      end
      SMul1: begin
        mb_q <= prod;
        nb_q <= (bd[32] != y1_q[31]);
      end
      SSum: begin
        if ((na_q && ma_q != 0) == (nb_q && mb_q != 0)) begin
          num_q <= 65'(ma_q) + 65'(mb_q);
          neg_q <= na_q && ma_q != 0;
        end else if (ma_q >= mb_q) begin
          num_q <= 65'(ma_q - mb_q);
          neg_q <= na_q && ma_q != 0;
        end else begin
          num_q <= 65'(mb_q - ma_q);
          neg_q <= nb_q && mb_q != 0;
        end
        den_q <= (span == '0) ? 33'd1 : 33'(span);
        rem_q <= '0;
        quo_q <= '0;
        bit_q <= 7'd64;
      end
      SDiv: begin
        if (trial >= {1'b0, den_q}) begin
          rem_q <= 33'(trial - {1'b0, den_q});
          quo_q <= {quo_q[63:0], 1'b1};
        end else begin
          rem_q <= trial[32:0];
          quo_q <= {quo_q[63:0], 1'b0};
        end
        num_q <= {num_q[63:0], 1'b0};
        bit_q <= bit_q - 1'b1;
      end
      SFin: begin
        if (neg_q) begin
          res_q.result_value <= (quo_q > 65'h80000000) ? 32'sh80000000
                                : 32'(-quo_q[32:0]);
        end else begin
          res_q.result_value <= (quo_q > 65'h7FFFFFFF) ? 32'sh7FFFFFFF
                                : quo_q[31:0];
        end
      end
      default: ;
    endcase
  end
endmodule

>>> src/pli_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module pli_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
